// ===== src/mcap_pkg.sv =====
// ----------------------------------------------------------------------------
// mcap_pkg: shared definitions for the multichannel average-to-position unit
// Holds the sizes, register indexes, calibration field layout and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mcap_pkg;

  // Channel and window geometry.
  localparam int CHANNELS    = 5;
  localparam int WINDOW      = 10;
  localparam int SAMPLE_BITS = 10;
  localparam int CH_W        = 3;
  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int TOTAL_W     = $clog2(WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int RING_DEPTH  = CHANNELS * WINDOW;
  localparam int RING_AW     = $clog2(RING_DEPTH);

  // Calibration word layout: min count, max count, range in Q8.8 mm.
  localparam int COUNT_W   = 10;
  localparam int RANGE_W   = 16;
  localparam int CAL_W     = 36;
  localparam int MIN_LSB   = 0;
  localparam int MAX_LSB   = 10;
  localparam int RANGE_LSB = 20;
  localparam logic [CAL_W-1:0] CAL_RESET = 36'd6711859300;

  // Register map.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_LAST = CFG_IDX_W'(CHANNELS - 1);
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = CFG_IDX_W'(CHANNELS);

  // Division of the window total by a constant: reciprocal and one correction.
  localparam int RECIP_SH = TOTAL_W;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / WINDOW);
  localparam int PROD_W   = TOTAL_W + RECIP_W;

  // Position divider: two quotient bits per cycle.
  localparam int NUM_W     = COUNT_W + RANGE_W;
  localparam int DIV_STEPS = (NUM_W + 1) / 2;
  localparam int DIV_W     = 2 * DIV_STEPS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic read;
    logic update;
    logic recip;
    logic avg;
    logic mul;
    logic div_step;
    logic emit;
  } mcap_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic take;
    logic out_full;
  } mcap_status_t;

endpackage

// ===== src/mcap_dp.sv =====
// ----------------------------------------------------------------------------
// mcap_dp: datapath of the multichannel average-to-position unit
// Configuration registers, per-channel sample rings and running totals,
// the window average, the calibration product, the iterative divider and
// the output register.
// ----------------------------------------------------------------------------
module mcap_dp
  import mcap_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CAL_W-1:0]       cfg_data,
  input  logic [CH_W-1:0]        channel,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  mcap_cmd_t              cmd,
  output mcap_status_t           st,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [CH_W-1:0]        out_channel,
  output logic [COUNT_W-1:0]     filtered_count,
  output logic [RANGE_W-1:0]     position
);

  // Configuration and per-channel state.
  logic [CAL_W-1:0]    cal_word     [CHANNELS];
  logic [CHANNELS-1:0] enable_mask;
  logic [SLOT_W-1:0]   write_slot   [CHANNELS];
  logic [TOTAL_W-1:0]  window_total [CHANNELS];

  // Ring memory with one valid bit per entry.
  logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic [RING_DEPTH-1:0]  ring_vld;
  logic [SAMPLE_BITS-1:0] ring_q;
  logic                   ring_vld_q;

  // Item registers.
  logic [CH_W-1:0]        ch_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [RING_AW-1:0]     addr_r;
  logic [TOTAL_W-1:0]     total_r;
  logic [PROD_W-1:0]      prod_r;
  logic [COUNT_W-1:0]     avg_r;
  logic [DIV_W-1:0]       quo;
  logic [COUNT_W-1:0]     rem;
  logic [COUNT_W-1:0]     den_r;
  logic                   neg_r;
  logic                   zden_r;

  // Combinational values.
  logic [RING_AW-1:0]     addr_c;
  logic [SLOT_W-1:0]      slot_c;
  logic [SAMPLE_BITS-1:0] old_c;
  logic [TOTAL_W-1:0]     total_new;
  logic [TOTAL_W-1:0]     q_est;
  logic [TOTAL_W-1:0]     r_est;
  logic [TOTAL_W-1:0]     q_fix;
  logic [COUNT_W-1:0]     cal_lo;
  logic [COUNT_W-1:0]     cal_hi;
  logic [RANGE_W-1:0]     cal_rng;
  logic [COUNT_W-1:0]     diff_mag;
  logic [COUNT_W-1:0]     den_mag;
  logic                   a_lt;
  logic                   d_lt;
  logic [DIV_W-1:0]       quo_next;
  logic [COUNT_W-1:0]     rem_next;
  logic [RANGE_W-1:0]     pos_c;

  // Item acceptance decision and output back-pressure.
  assign st.take     = (channel < CH_W'(CHANNELS)) && enable_mask[channel];
  assign st.out_full = out_valid && !out_ready;

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        cal_word[c] <= CAL_RESET;
      end
      enable_mask <= '0;
    end else if (cfg_we) begin
      if (cfg_index <= REG_CAL_LAST) begin
        cal_word[cfg_index] <= cfg_data;
      end else if (cfg_index == REG_ENABLE) begin
        enable_mask <= cfg_data[CHANNELS-1:0];
      end
    end
  end

  // Ring address of the entry to overwrite.
  assign slot_c = write_slot[ch_r];
  assign addr_c = RING_AW'(ch_r) * RING_AW'(WINDOW) + RING_AW'(slot_c);
  assign old_c  = ring_vld_q ? ring_q : '0;

  // Ring memory: registered read, single write port.
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      ring_q <= ring[addr_c];
    end
    if (cmd.update) begin
      ring[addr_r] <= smp_r;
    end
  end

  // Valid bits stand in for clearing the ring at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld   <= '0;
      ring_vld_q <= 1'b0;
    end else begin
      if (cmd.read) begin
        ring_vld_q <= ring_vld[addr_c];
      end
      if (cmd.update) begin
        ring_vld[addr_r] <= 1'b1;
      end
    end
  end

  // Running total with the oldest sample replaced by the new one.
  assign total_new = window_total[ch_r] - TOTAL_W'(old_c) + TOTAL_W'(smp_r);

  // Per-channel slot pointer and running total.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        write_slot[c]   <= '0;
        window_total[c] <= '0;
      end
    end else if (cmd.update) begin
      window_total[ch_r] <= total_new;
      if (slot_c == SLOT_W'(WINDOW - 1)) begin
        write_slot[ch_r] <= '0;
      end else begin
        write_slot[ch_r] <= slot_c + SLOT_W'(1);
      end
    end
  end

  // Window average: the reciprocal estimate is low by at most one.
  assign q_est = TOTAL_W'(prod_r >> RECIP_SH);
  assign r_est = total_r - TOTAL_W'(q_est * TOTAL_W'(WINDOW));
  assign q_fix = (r_est >= TOTAL_W'(WINDOW)) ? q_est + TOTAL_W'(1) : q_est;

  // Calibration fields of the current channel.
  assign cal_lo  = cal_word[ch_r][MIN_LSB +: COUNT_W];
  assign cal_hi  = cal_word[ch_r][MAX_LSB +: COUNT_W];
  assign cal_rng = cal_word[ch_r][RANGE_LSB +: RANGE_W];

  // Signed numerator and denominator split into magnitude and sign.
  assign a_lt     = avg_r < cal_lo;
  assign d_lt     = cal_hi < cal_lo;
  assign diff_mag = a_lt ? cal_lo - avg_r : avg_r - cal_lo;
  assign den_mag  = d_lt ? cal_lo - cal_hi : cal_hi - cal_lo;

  // Two restoring division steps per cycle.
  always_comb begin
    logic [COUNT_W:0] rsh;
    logic [COUNT_W-1:0] r;
    logic [DIV_W-1:0] q;
    r = rem;
    q = quo;
    for (int k = 0; k < 2; k++) begin
      rsh = {r, q[DIV_W-1]};
      q   = {q[DIV_W-2:0], 1'b0};
      if (rsh >= {1'b0, den_r}) begin
        rsh  = rsh - {1'b0, den_r};
        q[0] = 1'b1;
      end
      r = rsh[COUNT_W-1:0];
    end
    quo_next = q;
    rem_next = r;
  end

  // Clamp the quotient to [0, range]; equal calibration points give zero.
  always_comb begin
    if (zden_r || neg_r) begin
      pos_c = '0;
    end else if (quo > DIV_W'(cal_rng)) begin
      pos_c = cal_rng;
    end else begin
      pos_c = quo[RANGE_W-1:0];
    end
  end

  // Item pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r  <= channel;
      smp_r <= sample;
    end
    if (cmd.read) begin
      addr_r <= addr_c;
    end
    if (cmd.update) begin
      total_r <= total_new;
    end
    if (cmd.recip) begin
      prod_r <= PROD_W'(total_r) * PROD_W'(RECIP);
    end
    if (cmd.avg) begin
      avg_r <= COUNT_W'(q_fix);
    end
    if (cmd.mul) begin
      quo    <= DIV_W'(diff_mag) * DIV_W'(cal_rng);
      rem    <= '0;
      den_r  <= den_mag;
      neg_r  <= a_lt ^ d_lt;
      zden_r <= (cal_hi == cal_lo);
    end else if (cmd.div_step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_channel    <= ch_r;
      filtered_count <= avg_r;
      position       <= pos_c;
    end
  end

endmodule

// ===== src/mcap_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcap_ctrl: controller of the multichannel average-to-position unit
// Sequences one item through ring update, averaging, calibration product,
// division and the hand-off to the output register.
// ----------------------------------------------------------------------------
module mcap_ctrl
  import mcap_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  mcap_status_t st,
  output mcap_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_READ   = 8'b0000_0010,
    S_UPDATE = 8'b0000_0100,
    S_RECIP  = 8'b0000_1000,
    S_AVG    = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  assign in_ready = (state == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && st.take) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_RECIP;
      end
      S_RECIP: begin
        cmd.recip  = 1'b1;
        state_next = S_AVG;
      end
      S_AVG: begin
        cmd.avg    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        cnt_next   = CNT_W'(DIV_STEPS - 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - CNT_W'(1);
        if (cnt == '0) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!st.out_full) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== src/multichannel_average_to_position_unit.sv =====
// ----------------------------------------------------------------------------
// multichannel_average_to_position_unit: moving average with linear
// calibration to a position in Q8.8 millimetres, for five channels.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An enabled item goes from acceptance
// to its result in the output register through the ring read, the total
// update, the reciprocal multiply, the average correction and the
// calibration multiply, then the divider that retires two quotient bits a
// cycle, and a last step that loads the result. in_ready returns once the
// result is loaded, so no new item is taken before the last one is through;
// a result left waiting holds the next item in its last step. Items for a
// disabled or nonexistent channel are taken and produce no result.
// Configuration registers are to be written only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module multichannel_average_to_position_unit
  import mcap_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CAL_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CH_W-1:0]        channel,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CH_W-1:0]        out_channel,
  output logic [COUNT_W-1:0]     filtered_count,
  output logic [RANGE_W-1:0]     position
);

  mcap_cmd_t    cmd;
  mcap_status_t st;

  // Sequencer.
  mcap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  mcap_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .channel        (channel),
    .sample         (sample),
    .cmd            (cmd),
    .st             (st),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_channel    (out_channel),
    .filtered_count (filtered_count),
    .position       (position)
  );

  // A result only appears after the controller hands it to the output register.
  a_emit_before_valid: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result appeared without an emit command");

  // The controller issues at most one datapath command per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  // A dropped item leaves the block ready for the next one.
  a_drop_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !st.take) |=> in_ready)
    else $error("dropped item started processing");

  // The output register is never overwritten while a result waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("pending result overwritten");

endmodule

// ===== dv/multichannel_average_to_position_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_average_to_position_unit_test: self-checking testbench
// Sends channel-tagged converter samples through the unit, predicts each
// window average and calibrated position, and checks every result in order.
// Covers disabled and nonexistent channels, calibration corner cases, random
// calibration and enable settings, idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module multichannel_average_to_position_unit_test
  import mcap_pkg::*;
();

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 140;
  localparam int HOLD_ITEMS      = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_FIRST = '0;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = CFG_IDX_W'(CHANNELS + 1);

  typedef enum logic {RX_ALWAYS, RX_PATTERN} rx_mode_t;

  typedef enum logic [1:0] {
    LEVEL_UNIFORM,
    LEVEL_LOW,
    LEVEL_HIGH,
    LEVEL_STEADY
  } level_mode_t;

  typedef struct {
    logic [CH_W-1:0]    ch;
    logic [COUNT_W-1:0] avg;
    logic [RANGE_W-1:0] pos;
  } position_result_t;

  // Block ports.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CAL_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CH_W-1:0]        channel = '0;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CH_W-1:0]        out_channel;
  logic [COUNT_W-1:0]     filtered_count;
  logic [RANGE_W-1:0]     position;

  // Predicted filter state and configuration.
  logic [SAMPLE_BITS-1:0] ring_model [CHANNELS][WINDOW];
  int                     slot_model [CHANNELS];
  logic [TOTAL_W-1:0]     total_model [CHANNELS];
  logic [CAL_W-1:0]       cal_model [CHANNELS];
  logic [CHANNELS-1:0]    enable_model;

  position_result_t expected_results [$];
  position_result_t oldest_result;

  // Stimulus and bookkeeping.
  int       enabled_items = 0;
  int       dropped_items = 0;
  int       results_checked = 0;
  int       config_writes = 0;
  int       mismatches = 0;
  int       cycles = 0;
  int       burst_left = 0;
  bit       sender_gaps = 1'b0;
  bit       offering = 1'b0;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       hold_requests = 0;
  int       holds_served = 0;
  int       hold_left = 0;
  int       pattern_age = 0;
  logic [15:0] ready_pattern = '1;

  multichannel_average_to_position_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .channel        (channel),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .filtered_count (filtered_count),
    .position       (position)
  );

  // Free-running clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("multichannel_average_to_position_unit_test failed");
      $finish;
    end
  end

  // One line per mismatch, and a count for the final verdict.
  task automatic report_mismatch(input string what, input logic [RANGE_W-1:0] got,
                                 input logic [RANGE_W-1:0] want);
    mismatches++;
    $display("cycle %0d: mismatch on %s: got %0d, expected %0d", cycles, what, got, want);
  endtask

  function automatic logic [CAL_W-1:0] pack_cal(input int lo, input int hi, input int rng);
    return {RANGE_W'(rng), COUNT_W'(hi), COUNT_W'(lo)};
  endfunction

  // Work out the result of one accepted item and queue it.
  task automatic predict_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_BITS-1:0] s);
    position_result_t r;
    logic [TOTAL_W-1:0] avg_full;
    longint lo, hi, rng, q;
    int c;
    c = int'(ch);
    if (c >= CHANNELS || !enable_model[c]) begin
      dropped_items++;
      return;
    end
    total_model[c] = total_model[c] - ring_model[c][slot_model[c]] + s;
    ring_model[c][slot_model[c]] = s;
    slot_model[c] = (slot_model[c] + 1) % WINDOW;
    avg_full = total_model[c] / WINDOW;
    lo = longint'(cal_model[c][MIN_LSB +: COUNT_W]);
    hi = longint'(cal_model[c][MAX_LSB +: COUNT_W]);
    rng = longint'(cal_model[c][RANGE_LSB +: RANGE_W]);
    // Equal calibration points give zero; otherwise a signed quotient, clamped.
    if (hi == lo) begin
      q = 0;
    end else begin
      q = (longint'(avg_full) - lo) * rng / (hi - lo);
      if (q < 0) q = 0;
      if (q > rng) q = rng;
    end
    r.ch = ch;
    r.avg = avg_full[COUNT_W-1:0];
    r.pos = q[RANGE_W-1:0];
    expected_results.push_back(r);
    enabled_items++;
  endtask

  // Offer one item, wait for it to be taken, then maybe pause between bursts.
  task automatic send_item(input logic [CH_W-1:0] ch, input logic [SAMPLE_BITS-1:0] s);
    in_valid <= 1'b1;
    channel <= ch;
    sample <= s;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_sample(ch, s);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic stop_sending();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
  endtask

  // Let every outstanding result arrive, then let any dropped items settle.
  task automatic wait_idle();
    stop_sending();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx <= REG_CAL_LAST) cal_model[idx] = data;
    else if (idx == REG_ENABLE) enable_model = data[CHANNELS-1:0];
    config_writes++;
  endtask

  function automatic logic [CAL_W-1:0] random_cal();
    int lo;
    case ($urandom_range(0, 9))
      0: return CAL_W'({$urandom, $urandom});
      1: begin
        lo = $urandom_range(0, 1023);
        return pack_cal(lo, lo, $urandom_range(0, 65535));
      end
      2: return pack_cal($urandom_range(600, 1023), $urandom_range(0, 400),
                         $urandom_range(0, 65535));
      3: return pack_cal(0, 1023, 65535);
      default: return pack_cal($urandom_range(0, 300), $urandom_range(700, 1023),
                               $urandom_range(0, 65535));
    endcase
  endfunction

  // Output side: always ready, a rotating ready pattern, or a long hold-off on request.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (pattern_age == 0) begin
      ready_pattern = 16'($urandom | $urandom);
      pattern_age = 40;
    end else begin
      pattern_age--;
    end
    ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (rx_mode == RX_ALWAYS) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ready_pattern[15];
    end
  end

  // Compare each delivered result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, out_channel", out_channel, '0);
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_channel !== oldest_result.ch)
          report_mismatch("out_channel", out_channel, oldest_result.ch);
        if (filtered_count !== oldest_result.avg)
          report_mismatch("filtered_count", filtered_count, oldest_result.avg);
        if (position !== oldest_result.pos)
          report_mismatch("position", position, oldest_result.pos);
        results_checked++;
      end
    end
  end

  // With the reset mask every channel is disabled.
  task automatic test_disabled_channels();
    send_item(CH_W'(0), SAMPLE_BITS'(1023));
    send_item(CH_W'(4), SAMPLE_BITS'(0));
    send_item(CH_W'(7), SAMPLE_BITS'(1023));
    wait_idle();
  endtask

  // Reset calibration on all channels, plus channel numbers that do not exist.
  task automatic test_default_calibration();
    write_reg(REG_ENABLE, CAL_W'(5'h1F));
    send_item(CH_W'(0), SAMPLE_BITS'(1023));
    send_item(CH_W'(0), SAMPLE_BITS'(1023));
    send_item(CH_W'(1), SAMPLE_BITS'(0));
    send_item(CH_W'(2), SAMPLE_BITS'(512));
    send_item(CH_W'(5), SAMPLE_BITS'(100));
    send_item(CH_W'(6), SAMPLE_BITS'(200));
    send_item(CH_W'(3), SAMPLE_BITS'(1023));
    send_item(CH_W'(4), SAMPLE_BITS'(1023));
    wait_idle();
  endtask

  // Clamp above range, inverted points, full span, equal points.
  task automatic test_calibration_corners();
    int i;
    write_reg(REG_CAL_FIRST + CFG_IDX_W'(0), pack_cal(0, 50, 1000));
    write_reg(REG_CAL_FIRST + CFG_IDX_W'(1), pack_cal(900, 100, 6400));
    write_reg(REG_CAL_FIRST + CFG_IDX_W'(2), pack_cal(0, 1023, 65535));
    write_reg(REG_CAL_FIRST + CFG_IDX_W'(3), pack_cal(300, 300, 6400));
    write_reg(REG_CAL_FIRST + CFG_IDX_W'(4), '1);
    // Writes past the register list must leave everything alone.
    for (i = int'(REG_SPARE); i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), '1);
    send_item(CH_W'(0), SAMPLE_BITS'(1023));
    send_item(CH_W'(1), SAMPLE_BITS'(0));
    send_item(CH_W'(1), SAMPLE_BITS'(1023));
    send_item(CH_W'(2), SAMPLE_BITS'(1023));
    send_item(CH_W'(2), SAMPLE_BITS'(1023));
    send_item(CH_W'(3), SAMPLE_BITS'(1023));
    send_item(CH_W'(4), SAMPLE_BITS'(1023));
    wait_idle();
  endtask

  // Alternate channels disabled, one channel with an all-zero calibration word.
  task automatic test_partial_mask();
    write_reg(REG_CAL_FIRST + CFG_IDX_W'(3), '0);
    write_reg(REG_ENABLE, CAL_W'(5'b01010));
    send_item(CH_W'(0), SAMPLE_BITS'(1023));
    send_item(CH_W'(1), SAMPLE_BITS'(1023));
    send_item(CH_W'(2), SAMPLE_BITS'(1023));
    send_item(CH_W'(3), SAMPLE_BITS'(1023));
    send_item(CH_W'(4), SAMPLE_BITS'(0));
    wait_idle();
  endtask

  // Random calibration, masks, sample levels and idling, phase by phase.
  task automatic test_random_phases();
    int phase, c, start_count;
    logic [CHANNELS-1:0] mask;
    level_mode_t level_mode;
    logic [SAMPLE_BITS-1:0] level [CHANNELS];
    logic [SAMPLE_BITS-1:0] s;
    logic [CH_W-1:0] ch;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      for (c = 0; c < CHANNELS; c++) begin
        write_reg(REG_CAL_FIRST + CFG_IDX_W'(c), random_cal());
        level[c] = SAMPLE_BITS'($urandom);
      end
      if (phase == 0) mask = '1;
      else if (phase == PHASES - 1) mask = CHANNELS'(1) << $urandom_range(0, CHANNELS - 1);
      else begin
        do mask = CHANNELS'($urandom); while (mask == '0);
      end
      write_reg(REG_ENABLE, CAL_W'(mask));
      sender_gaps = (phase != 0) && ($urandom_range(0, 3) != 0);
      rx_mode = (phase == 0 || $urandom_range(0, 3) == 0) ? RX_ALWAYS : RX_PATTERN;
      level_mode = level_mode_t'($urandom_range(0, 3));
      start_count = enabled_items;
      while (enabled_items - start_count < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) begin
          ch = CH_W'($urandom);
        end else begin
          do ch = CH_W'($urandom_range(0, CHANNELS - 1)); while (!mask[ch]);
        end
        case (level_mode)
          LEVEL_UNIFORM: s = SAMPLE_BITS'($urandom);
          LEVEL_LOW:     s = SAMPLE_BITS'($urandom_range(0, 63));
          LEVEL_HIGH:    s = SAMPLE_BITS'($urandom_range(960, 1023));
          default: begin
            if (int'(ch) < CHANNELS) s = level[ch] ^ SAMPLE_BITS'($urandom_range(0, 7));
            else s = SAMPLE_BITS'($urandom);
          end
        endcase
        send_item(ch, s);
      end
    end
    wait_idle();
  endtask

  // Output held off for a long stretch while items keep coming.
  task automatic test_output_hold_off();
    int i;
    write_reg(REG_ENABLE, CAL_W'(5'h1F));
    sender_gaps = 1'b0;
    rx_mode = RX_PATTERN;
    hold_requests++;
    for (i = 0; i < HOLD_ITEMS; i++)
      send_item(CH_W'($urandom_range(0, CHANNELS - 1)), SAMPLE_BITS'($urandom));
    wait_idle();
    rx_mode = RX_ALWAYS;
  endtask

  initial begin
    int c, w, drain;
    for (c = 0; c < CHANNELS; c++) begin
      for (w = 0; w < WINDOW; w++) ring_model[c][w] = '0;
      slot_model[c] = 0;
      total_model[c] = '0;
      cal_model[c] = CAL_RESET;
    end
    enable_model = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled_channels();
    test_default_calibration();
    test_calibration_corners();
    test_partial_mask();
    test_output_hold_off();
    test_random_phases();

    stop_sending();
    drain = 0;
    while (expected_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered, count", RANGE_W'(expected_results.size()), '0);

    $display("Ran %0d enabled and %0d dropped items, checked %0d results,",
             enabled_items, dropped_items, results_checked);
    $display("over %0d register writes in %0d cycles; %0d mismatches.",
             config_writes, cycles, mismatches);
    if (mismatches == 0) begin
      $display("multichannel_average_to_position_unit_test passed");
    end else begin
      $display("multichannel_average_to_position_unit_test failed");
    end
    $finish;
  end

endmodule
